// ===== hw/rtl/dlsf_pkg.sv =====
// Package for the datagram link-state filter: command, phase and role codes,
// register indexes, reset values and the queue entry type.
// No dependencies.
package dlsf_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] PROTOCOL_RESET = 32'd0;
	localparam logic [31:0] TIMEOUT_RESET  = 32'd10000;

	localparam logic [15:0] HEADER_BYTES = 16'd4;
	localparam logic [31:0] SILENCE_MAX  = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_LISTEN  = 2'd0,
		MODE_CONNECT = 2'd1,
		MODE_TICK    = 2'd2,
		MODE_PACKET  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_DISCONNECTED = 3'd0,
		PH_LISTENING    = 3'd1,
		PH_CONNECTING   = 3'd2,
		PH_CONNECTED    = 3'd3,
		PH_FAILED       = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_NONE   = 2'd0,
		ROLE_SERVER = 2'd1,
		ROLE_CLIENT = 2'd2
	} role_t;

	typedef enum logic {
		REG_PROTOCOL = 1'b0,
		REG_TIMEOUT  = 1'b1
	} reg_index_t;

	typedef struct packed {
		mode_t       mode;
		logic        header_ok;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [15:0] elapsed;
		logic [15:0] payload_length;
	} entry_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] payload_length;
		logic [2:0]  link_state;
		logic        connect_event;
		logic        disconnect_event;
		logic        send_allowed;
	} result_t;

endpackage

// ===== hw/rtl/dlsf_ifs.sv =====
// Request channels of the datagram link-state filter: command in, result out.
// Valid/ready handshake; depends on nothing.
interface dlsf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] peer_ip;
	logic [15:0] peer_port;
	logic [15:0] elapsed;
	logic [31:0] header_word;
	logic [15:0] packet_length;

	modport source (output valid, mode, peer_ip, peer_port, elapsed, header_word,
		packet_length, input ready);
	modport sink (input valid, mode, peer_ip, peer_port, elapsed, header_word,
		packet_length, output ready);
endinterface

interface dlsf_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [15:0] payload_length;
	logic [2:0]  link_state;
	logic        connect_event;
	logic        disconnect_event;
	logic        send_allowed;

	modport source (output valid, accepted, payload_length, link_state, connect_event,
		disconnect_event, send_allowed, input ready);
	modport sink (input valid, accepted, payload_length, link_state, connect_event,
		disconnect_event, send_allowed, output ready);
endinterface

// ===== hw/rtl/dlsf_front.sv =====
// Front end: takes command requests, checks length and protocol word, and
// forms a queue entry. Depends on dlsf_pkg and dlsf_in_if.
module dlsf_front (
	dlsf_in_if.sink         in_ch,
	input  logic [31:0]     protocol_word,
	input  logic            push_ready,
	output logic            push_valid,
	output dlsf_pkg::entry_t push_entry
);

	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid;

	always_comb begin
		push_entry.mode           = dlsf_pkg::mode_t'(in_ch.mode);
		push_entry.header_ok      = (in_ch.packet_length > dlsf_pkg::HEADER_BYTES) &&
			(in_ch.header_word == protocol_word);
		push_entry.peer_ip        = in_ch.peer_ip;
		push_entry.peer_port      = in_ch.peer_port;
		push_entry.elapsed        = in_ch.elapsed;
		push_entry.payload_length = in_ch.packet_length - dlsf_pkg::HEADER_BYTES;
	end

endmodule

// ===== hw/rtl/dlsf_queue.sv =====
// Short queue between front and back end of the link-state filter.
// Depends on dlsf_pkg.
module dlsf_queue #(
	parameter int Depth = dlsf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  dlsf_pkg::entry_t push_entry,
	output logic             push_ready,
	input  logic             pop,
	output logic             pop_valid,
	output dlsf_pkg::entry_t pop_entry
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	dlsf_pkg::entry_t slots_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != FullCnt);
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/dlsf_back.sv =====
// Back end: applies queued commands to the link state and holds the result
// in an output register. Depends on dlsf_pkg and dlsf_out_if.
module dlsf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      timeout_limit,
	input  logic             pop_valid,
	input  dlsf_pkg::entry_t pop_entry,
	output logic             pop,
	dlsf_out_if.source       out_ch
);

	dlsf_pkg::phase_t  phase_q, phase_d;
	dlsf_pkg::role_t   role_q, role_d;
	logic [31:0]       peer_ip_q, peer_ip_d;
	logic [15:0]       peer_port_q, peer_port_d;
	logic [31:0]       silence_q, silence_d;
	logic [32:0]       silence_sum;
	logic              out_valid_q;
	dlsf_pkg::result_t res_q, res_d;

	assign pop = pop_valid && (!out_valid_q || out_ch.ready);

	assign silence_sum = {1'b0, silence_q} + {17'd0, pop_entry.elapsed};

	always_comb begin
		phase_d     = phase_q;
		role_d      = role_q;
		peer_ip_d   = peer_ip_q;
		peer_port_d = peer_port_q;
		silence_d   = silence_q;
		res_d       = '0;
		case (pop_entry.mode)
			dlsf_pkg::MODE_LISTEN, dlsf_pkg::MODE_CONNECT: begin
				res_d.disconnect_event = (phase_q == dlsf_pkg::PH_CONNECTED);
				silence_d = '0;
				if (pop_entry.mode == dlsf_pkg::MODE_LISTEN) begin
					role_d      = dlsf_pkg::ROLE_SERVER;
					phase_d     = dlsf_pkg::PH_LISTENING;
					peer_ip_d   = '0;
					peer_port_d = '0;
				end else begin
					role_d      = dlsf_pkg::ROLE_CLIENT;
					phase_d     = dlsf_pkg::PH_CONNECTING;
					peer_ip_d   = pop_entry.peer_ip;
					peer_port_d = pop_entry.peer_port;
				end
			end
			dlsf_pkg::MODE_TICK: begin
				silence_d = silence_sum[32] ? dlsf_pkg::SILENCE_MAX : silence_sum[31:0];
				if (silence_d > timeout_limit) begin
					if (phase_q == dlsf_pkg::PH_CONNECTING ||
						phase_q == dlsf_pkg::PH_CONNECTED) begin
						phase_d = (phase_q == dlsf_pkg::PH_CONNECTING) ?
							dlsf_pkg::PH_FAILED : dlsf_pkg::PH_DISCONNECTED;
						silence_d   = '0;
						peer_ip_d   = '0;
						peer_port_d = '0;
						res_d.disconnect_event = 1'b1;
					end
				end
			end
			dlsf_pkg::MODE_PACKET: begin
				if (pop_entry.header_ok) begin
					if (role_q == dlsf_pkg::ROLE_SERVER &&
						phase_q != dlsf_pkg::PH_CONNECTED) begin
						phase_d     = dlsf_pkg::PH_CONNECTED;
						peer_ip_d   = pop_entry.peer_ip;
						peer_port_d = pop_entry.peer_port;
						res_d.connect_event = 1'b1;
					end
					if (pop_entry.peer_ip == peer_ip_d && pop_entry.peer_port == peer_port_d) begin
						if (role_q == dlsf_pkg::ROLE_CLIENT &&
							phase_q == dlsf_pkg::PH_CONNECTING) begin
							phase_d = dlsf_pkg::PH_CONNECTED;
							res_d.connect_event = 1'b1;
						end
						silence_d            = '0;
						res_d.accepted       = 1'b1;
						res_d.payload_length = pop_entry.payload_length;
					end
				end
			end
			default: begin
			end
		endcase
		res_d.link_state   = phase_d;
		res_d.send_allowed = (peer_ip_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dlsf_pkg::PH_DISCONNECTED;
			role_q      <= dlsf_pkg::ROLE_NONE;
			peer_ip_q   <= '0;
			peer_port_q <= '0;
			silence_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				role_q      <= role_d;
				peer_ip_q   <= peer_ip_d;
				peer_port_q <= peer_port_d;
				silence_q   <= silence_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.accepted         = res_q.accepted;
	assign out_ch.payload_length   = res_q.payload_length;
	assign out_ch.link_state       = res_q.link_state;
	assign out_ch.connect_event    = res_q.connect_event;
	assign out_ch.disconnect_event = res_q.disconnect_event;
	assign out_ch.send_allowed     = res_q.send_allowed;

endmodule

// ===== hw/rtl/datagram_link_state_filter_top.sv =====
// Top level of the datagram link-state filter: APB registers, front end,
// queue and back end. Depends on dlsf_pkg, dlsf_ifs, dlsf_front, dlsf_queue, dlsf_back.
//
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      mode, peer_ip, peer_port, elapsed, header_word,
//                                 packet_length
// out_ch    out  valid/ready      accepted, payload_length, link_state,
//                                 connect_event, disconnect_event, send_allowed
// apb       in   psel/penable     protocol_word at 0x0, timeout_limit at 0x4
//
// One request per cycle sustained while out_ch.ready holds; a result is registered
// after its request is accepted: queue write, then back-end state update into the
// output register.
// The state update in the back end sets the rate.
// Reset clears link state, queue and output valid; registers take their defaults.
// A stalled output fills the queue; in_ch.ready drops only when the queue is full.
module datagram_link_state_filter_top #(
	parameter int QueueDepth = dlsf_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	dlsf_in_if.sink     in_ch,
	dlsf_out_if.source  out_ch
);

	logic [31:0]         protocol_word_q, timeout_limit_q;
	logic                reg_write;
	dlsf_pkg::reg_index_t reg_sel;
	logic                push_valid, push_ready, pop, pop_valid;
	dlsf_pkg::entry_t    push_entry, pop_entry;

	assign pready    = 1'b1;
	assign reg_sel   = dlsf_pkg::reg_index_t'(paddr[2]);
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_word_q <= dlsf_pkg::PROTOCOL_RESET;
			timeout_limit_q <= dlsf_pkg::TIMEOUT_RESET;
		end else if (reg_write) begin
			case (reg_sel)
				dlsf_pkg::REG_PROTOCOL: protocol_word_q <= pwdata;
				dlsf_pkg::REG_TIMEOUT:  timeout_limit_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			dlsf_pkg::REG_PROTOCOL: prdata = protocol_word_q;
			dlsf_pkg::REG_TIMEOUT:  prdata = timeout_limit_q;
			default:                prdata = '0;
		endcase
	end

	dlsf_front u_front (
		.in_ch         (in_ch),
		.protocol_word (protocol_word_q),
		.push_ready    (push_ready),
		.push_valid    (push_valid),
		.push_entry    (push_entry)
	);

	dlsf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	dlsf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_limit (timeout_limit_q),
		.pop_valid     (pop_valid),
		.pop_entry     (pop_entry),
		.pop           (pop),
		.out_ch        (out_ch)
	);

endmodule
